// ----- rtl/mcpdf_pkg.sv -----
// ----------------------------------------------------------------------------
// mcpdf_pkg
// Shared types and constants for the MIDI channel parser and duplicate filter.
// ----------------------------------------------------------------------------
package mcpdf_pkg;

  localparam int FILTER_DEPTH = 6;
  localparam int IDX_W        = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int EW_W         = $clog2(FILTER_DEPTH + 1);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_WIDTH,
    REG_NOTE_GRAN,
    REG_VEL_GRAN,
    REG_PRESS_GRAN
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OUT_TAKEN,
    OUT_IGNORED,
    OUT_DUPLICATE,
    OUT_COMPLETE
  } outcome_t;

  localparam logic [1:0] LEN_NONE  = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  localparam logic [1:0] POS_IDLE = 2'd0;
  localparam logic [1:0] POS_D1   = 2'd1;
  localparam logic [1:0] POS_D2   = 2'd2;

  localparam logic [7:0] NOTE_MAX     = 8'h9F;
  localparam logic [7:0] TWO_BYTE_MIN = 8'hC0;
  localparam logic [7:0] PRESS_MIN    = 8'hD0;
  localparam logic [7:0] PRESS_MAX    = 8'hDF;

  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_PRESS    = 4'hD;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] d1;
    logic [6:0] d2;
  } entry_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] d1;
  } pr_entry_t;

endpackage

// ----- rtl/mcpdf_in_if.sv -----
// ----------------------------------------------------------------------------
// mcpdf_in_if
// Input channel: one raw MIDI byte per item.
// ----------------------------------------------------------------------------
interface mcpdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source(output valid, output midi_byte, input ready);
  modport sink(input valid, input midi_byte, output ready);
endinterface

// ----- rtl/mcpdf_out_if.sv -----
// ----------------------------------------------------------------------------
// mcpdf_out_if
// Result channel: outcome and assembled message per item.
// ----------------------------------------------------------------------------
interface mcpdf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  logic [1:0] msg_length;
  logic [7:0] msg_status;
  logic [6:0] msg_data1;
  logic [6:0] msg_data2;

  modport source(output valid, output outcome, output msg_length, output msg_status,
                 output msg_data1, output msg_data2, input ready);
  modport sink(input valid, input outcome, input msg_length, input msg_status,
               input msg_data1, input msg_data2, output ready);
endinterface

// ----- rtl/mcpdf_cmp.sv -----
// ----------------------------------------------------------------------------
// mcpdf_cmp
// Shared compare unit: matches a message against one stored ring entry.
// ----------------------------------------------------------------------------
module mcpdf_cmp (
  input  mcpdf_pkg::entry_t entry,
  input  mcpdf_pkg::entry_t msg,
  input  logic [6:0]        gran1,
  input  logic [6:0]        gran2,
  output logic              match
);
  import mcpdf_pkg::*;

  logic [6:0] diff1;
  logic [6:0] diff2;
  logic       ok1;
  logic       ok2;

  assign diff1 = (msg.d1 >= entry.d1) ? msg.d1 - entry.d1 : entry.d1 - msg.d1;
  assign diff2 = (msg.d2 >= entry.d2) ? msg.d2 - entry.d2 : entry.d2 - msg.d2;

  // zero granularity skips that field
  assign ok1 = (gran1 == '0) || (diff1 <= gran1);
  assign ok2 = (gran2 == '0) || (diff2 <= gran2);

  assign match = (entry.status == msg.status) && ok1 && ok2;

endmodule

// ----- rtl/midi_channel_parser_dup_filter_top.sv -----
// ----------------------------------------------------------------------------
// midi_channel_parser_dup_filter_top
// MIDI running-status parser with a duplicate filter over per-kind rings.
// Flow: a byte is accepted only in the idle state; a complete message is
//   scanned against up to N = min(filter_width, 6) entries of its ring.
//   The single compare unit walks the ring one entry per cycle, stopping at a
//   match; the next byte waits until the result is in the output register.
//   Reset: synchronous; clears parser, rings, slots and configuration registers.
// ----------------------------------------------------------------------------
module midi_channel_parser_dup_filter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mcpdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mcpdf_pkg::CFG_DATA_W-1:0]    cfg_data,
  mcpdf_in_if.sink                            midi,
  mcpdf_out_if.source                         result
);
  import mcpdf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;
  typedef enum logic [1:0] {KIND_ON, KIND_OFF, KIND_PR} kind_t;

  state_t     state;
  kind_t      kind;
  logic [IDX_W-1:0] idx;

  logic [2:0] filter_width;
  logic [6:0] note_window;
  logic [6:0] vel_gran;
  logic [6:0] press_gran;

  logic [7:0] running_status;
  logic [1:0] data_position;
  logic [6:0] pending_data1;

  entry_t     ring_on  [FILTER_DEPTH];
  entry_t     ring_off [FILTER_DEPTH];
  pr_entry_t  ring_pr  [FILTER_DEPTH];
  logic [IDX_W-1:0] slot_on;
  logic [IDX_W-1:0] slot_off;
  logic [IDX_W-1:0] slot_pr;

  outcome_t   msg_outcome;
  logic [1:0] msg_len;
  entry_t     msg;

  logic       out_valid;
  outcome_t   out_outcome;
  logic [1:0] out_len;
  entry_t     out_msg;

  logic [7:0] b;
  logic [EW_W-1:0] eff_w;
  outcome_t   p_outcome;
  logic [1:0] p_len;
  entry_t     p_msg;
  logic [7:0] rs_next;
  logic [1:0] pos_next;
  logic [6:0] pend_next;
  logic [3:0] hi;
  logic       p_scan;
  kind_t      p_kind;

  entry_t     cur_entry;
  logic [6:0] gran1;
  logic [6:0] gran2;
  logic       match;
  logic       last;
  logic [IDX_W-1:0] cur_slot;
  logic [IDX_W-1:0] store_idx;
  logic [EW_W-1:0]  slot_inc;
  logic [IDX_W-1:0] slot_next;
  logic       accept;
  logic       out_free;

  assign b        = midi.midi_byte;
  assign accept   = midi.valid && midi.ready;
  assign midi.ready = (state == S_IDLE);
  assign out_free = !out_valid || result.ready;

  assign eff_w = (32'(filter_width) > FILTER_DEPTH) ? EW_W'(FILTER_DEPTH)
                                                    : EW_W'(filter_width);

  always_comb begin
    p_outcome = OUT_TAKEN;
    p_len     = LEN_NONE;
    p_msg     = '0;
    rs_next   = running_status;
    pos_next  = data_position;
    pend_next = pending_data1;
    if (!b[7]) begin
      if (running_status == '0) begin
        p_outcome = OUT_IGNORED;
      end else if (data_position == POS_D1) begin
        if (running_status >= TWO_BYTE_MIN && running_status <= PRESS_MAX) begin
          p_len        = LEN_TWO;
          p_msg.status = running_status;
          p_msg.d1     = b[6:0];
        end else begin
          pend_next = b[6:0];
          pos_next  = POS_D2;
        end
      end else if (data_position == POS_D2) begin
        p_len        = LEN_THREE;
        p_msg.status = running_status;
        p_msg.d1     = pending_data1;
        p_msg.d2     = b[6:0];
        pos_next     = POS_D1;
      end
    end else if (b <= NOTE_MAX || (b >= PRESS_MIN && b <= PRESS_MAX)) begin
      rs_next  = b;
      pos_next = POS_D1;
    end else begin
      rs_next   = '0;
      pos_next  = POS_IDLE;
      p_outcome = OUT_IGNORED;
    end
    if (p_len != LEN_NONE) begin
      p_outcome = OUT_COMPLETE;
    end
  end

  assign hi = p_msg.status[7:4];

  always_comb begin
    p_kind = KIND_PR;
    if (hi == HI_NOTE_ON) begin
      p_kind = KIND_ON;
    end else if (hi == HI_NOTE_OFF) begin
      p_kind = KIND_OFF;
    end
  end

  assign p_scan = (p_len != LEN_NONE) && (eff_w != '0) &&
                  (hi == HI_NOTE_ON || hi == HI_NOTE_OFF ||
                   (hi == HI_PRESS && press_gran != '0));

  always_comb begin
    unique case (kind)
      KIND_ON: begin
        cur_entry = ring_on[idx];
        cur_slot  = slot_on;
      end
      KIND_OFF: begin
        cur_entry = ring_off[idx];
        cur_slot  = slot_off;
      end
      KIND_PR: begin
        cur_entry = {ring_pr[idx], 7'd0};
        cur_slot  = slot_pr;
      end
      default: begin
        cur_entry = '0;
        cur_slot  = '0;
      end
    endcase
  end

  assign gran1 = (kind == KIND_PR) ? press_gran : note_window;
  assign gran2 = (kind == KIND_PR) ? 7'd0 : vel_gran;

  mcpdf_cmp u_cmp (
    .entry (cur_entry),
    .msg   (msg),
    .gran1 (gran1),
    .gran2 (gran2),
    .match (match)
  );

  assign last      = (EW_W'(idx) + EW_W'(1)) == eff_w;
  assign store_idx = (32'(cur_slot) < FILTER_DEPTH) ? cur_slot : '0;
  assign slot_inc  = EW_W'(cur_slot) + EW_W'(1);
  assign slot_next = (slot_inc >= eff_w) ? '0 : IDX_W'(slot_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_width <= '0;
      note_window  <= '0;
      vel_gran     <= '0;
      press_gran   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FILTER_WIDTH: filter_width <= cfg_data[2:0];
        REG_NOTE_GRAN:    note_window  <= cfg_data;
        REG_VEL_GRAN:     vel_gran     <= cfg_data;
        REG_PRESS_GRAN:   press_gran   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      kind           <= KIND_ON;
      idx            <= '0;
      running_status <= '0;
      data_position  <= POS_IDLE;
      pending_data1  <= '0;
      slot_on        <= '0;
      slot_off       <= '0;
      slot_pr        <= '0;
      out_valid      <= 1'b0;
      msg_outcome    <= OUT_TAKEN;
      msg_len        <= LEN_NONE;
      msg            <= '0;
      for (int i = 0; i < FILTER_DEPTH; i++) begin
        ring_on[i]  <= '0;
        ring_off[i] <= '0;
        ring_pr[i]  <= '0;
      end
    end else begin
      if (out_valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            running_status <= rs_next;
            data_position  <= pos_next;
            pending_data1  <= pend_next;
            msg_outcome    <= p_outcome;
            msg_len        <= p_len;
            msg            <= p_msg;
            kind           <= p_kind;
            idx            <= '0;
            state          <= p_scan ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (match) begin
            msg_outcome <= OUT_DUPLICATE;
            state       <= S_DONE;
          end else if (last) begin
            unique case (kind)
              KIND_ON: begin
                ring_on[store_idx] <= msg;
                slot_on            <= slot_next;
              end
              KIND_OFF: begin
                ring_off[store_idx] <= msg;
                slot_off            <= slot_next;
              end
              default: begin
                ring_pr[store_idx] <= {msg.status, msg.d1};
                slot_pr            <= slot_next;
              end
            endcase
            state <= S_DONE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_outcome <= msg_outcome;
            out_len     <= msg_len;
            out_msg     <= msg;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid      = out_valid;
  assign result.outcome    = out_outcome;
  assign result.msg_length = out_len;
  assign result.msg_status = out_msg.status;
  assign result.msg_data1  = out_msg.d1;
  assign result.msg_data2  = out_msg.d2;

endmodule

// ----- rtl/mcpdf_chk.sv -----
// ----------------------------------------------------------------------------
// mcpdf_chk
// Port-level checks for the MIDI parser and duplicate filter.
// ----------------------------------------------------------------------------
module mcpdf_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] outcome,
  input logic [1:0] msg_length,
  input logic [6:0] msg_data2
);
  import mcpdf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  a_len_matches_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((outcome == OUT_TAKEN || outcome == OUT_IGNORED) ==
                   (msg_length == LEN_NONE)))
    else $error("message length disagrees with outcome");

  a_two_byte_no_data2: assert property (@(posedge clk) disable iff (rst)
    out_valid && msg_length == LEN_TWO |-> msg_data2 == '0)
    else $error("two-byte message carries second data byte");

endmodule

bind midi_channel_parser_dup_filter_top mcpdf_chk u_mcpdf_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (midi.valid),
  .in_ready   (midi.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .outcome    (result.outcome),
  .msg_length (result.msg_length),
  .msg_data2  (result.msg_data2)
);
